/* src/rmv_pkg.sv */
// Package for the running mean and variance block: widths, state codes and
// the request/response structs between the controller and the serial units.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rmv_pkg;

    localparam int COUNT_BITS  = 32;
    localparam int SAMPLE_W    = 32;
    localparam int FRAC_SHIFT  = 16;
    localparam int MEAN_W      = SAMPLE_W + FRAC_SHIFT;
    localparam int SUM_W       = 64;
    localparam int CNT_OUT_W   = 32;
    localparam int MAG_W       = MEAN_W;
    localparam int NUM_W       = MAG_W + 1;
    localparam int DIV_W       = SUM_W;
    localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
    localparam int PROD_W      = 2 * MAG_W;
    localparam int PROD_SHIFT  = 32;
    localparam int TERM_W      = PROD_W - PROD_SHIFT;
    localparam int MUL_DIGIT   = 2;
    localparam int MUL_STEPS   = MAG_W / MUL_DIGIT;
    localparam int MUL_CNT_W   = $clog2(MUL_STEPS + 1);
    localparam int MUL_ACC_W   = MAG_W + MUL_DIGIT;
    localparam int CNT_EXT_W   = ((COUNT_BITS > CNT_OUT_W) ? COUNT_BITS : CNT_OUT_W) + 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;
    localparam logic [CNT_OUT_W-1:0]  CNT_OUT_MAX = '1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_DIV_GO,
        S_DIV_MEAN,
        S_D2,
        S_MUL,
        S_ACC,
        S_VAR_GO,
        S_DIV_VAR,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [DIV_W-1:0]      dividend;
        logic [COUNT_BITS-1:0] divisor;
        logic [DIV_CNT_W-1:0]  steps;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [DIV_W-1:0]      quot;
        logic [COUNT_BITS-1:0] rem;
    } t_div_rsp;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] a;
        logic [MAG_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] prod;
    } t_mul_rsp;

endpackage

`default_nettype wire

/* src/rmv_if.sv */
// Handshake interfaces for the sample channel and the result channel.
// Depends on rmv_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rmv_in_if import rmv_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface rmv_out_if import rmv_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] mean_out;
    logic [SUM_W-1:0]           variance_out;
    logic [CNT_OUT_W-1:0]       sample_count;
    logic                       saturated;

    modport source (output valid, output mean_out, output variance_out,
                    output sample_count, output saturated, input ready);
    modport sink   (input valid, input mean_out, input variance_out,
                    input sample_count, input saturated, output ready);
endinterface

`default_nettype wire

/* src/rmv_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// Depends on rmv_pkg (t_div_req, t_div_rsp).
`timescale 1ns / 1ps
`default_nettype none

module rmv_div import rmv_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [DIV_W-1:0]      r_dvd;
    logic [DIV_W-1:0]      r_quo;
    logic [COUNT_BITS-1:0] r_rem;
    logic [COUNT_BITS-1:0] r_dvs;

    logic [COUNT_BITS+1:0] w_trial;
    logic                  w_ge;

    assign w_trial = {1'b0, r_rem, r_dvd[DIV_W-1]} - {2'b00, r_dvs};
    assign w_ge    = !w_trial[COUNT_BITS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == DIV_CNT_W'(1));
            if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end else if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_dvd <= {r_dvd[DIV_W-2:0], 1'b0};
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
            r_rem <= w_ge ? w_trial[COUNT_BITS-1:0] : {r_rem[COUNT_BITS-2:0], r_dvd[DIV_W-1]};
        end else if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_quo <= '0;
            r_rem <= '0;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

/* src/rmv_mul.sv */
// Digit-serial unsigned multiplier: two multiplier bits per cycle, shift-add
// with a precomputed triple of the multiplicand. Depends on rmv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rmv_mul import rmv_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mul_req i_req,
    output t_mul_rsp      o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [MAG_W-1:0]     r_a;
    logic [MUL_ACC_W-1:0] r_a3;
    logic [MAG_W-1:0]     r_hi;
    logic [MAG_W-1:0]     r_lo;

    logic [MUL_ACC_W-1:0] w_sel;
    logic [MUL_ACC_W-1:0] w_sum;

    always_comb begin
        case (r_lo[MUL_DIGIT-1:0])
            2'd0:    w_sel = '0;
            2'd1:    w_sel = MUL_ACC_W'(r_a);
            2'd2:    w_sel = {1'b0, r_a, 1'b0};
            default: w_sel = r_a3;
        endcase
    end

    assign w_sum = MUL_ACC_W'(r_hi) + w_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == MUL_CNT_W'(1));
            if (r_busy) begin
                r_cnt <= r_cnt - MUL_CNT_W'(1);
                if (r_cnt == MUL_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end else if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= MUL_CNT_W'(MUL_STEPS);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_hi <= w_sum[MUL_ACC_W-1:MUL_DIGIT];
            r_lo <= {w_sum[MUL_DIGIT-1:0], r_lo[MAG_W-1:MUL_DIGIT]};
        end else if (i_req.start) begin
            r_a  <= i_req.a;
            r_a3 <= MUL_ACC_W'(i_req.a) + {1'b0, i_req.a, 1'b0};
            r_hi <= '0;
            r_lo <= i_req.b;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = {r_hi, r_lo};

endmodule

`default_nettype wire

/* src/running_mean_variance.sv */
// Running mean and population variance, Welford update per sample.
// A sample is accepted only in the idle state, after the previous sample's
// update is done; a last-marked sample also waits for the variance division and
// the result hand-off. The serial divider (49 steps per mean update, 64 for the
// variance) and the 2-bit serial multiplier do the work.
// Reset: synchronous, active low; clears mean, sum, count, flag and handshakes.
`timescale 1ns / 1ps
`default_nettype none

module running_mean_variance import rmv_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rmv_in_if.sink     i_in,
    rmv_out_if.source  o_out
);

    t_state n_state;
    t_state r_state;

    logic signed [MEAN_W-1:0] r_mean;
    logic [SUM_W-1:0]         r_sum;
    logic [COUNT_BITS-1:0]    r_count;
    logic                     r_flag;
    logic                     r_out_valid;

    logic [SAMPLE_W-1:0]      r_sample;
    logic                     r_last;
    logic [MAG_W-1:0]         r_dm;
    logic                     r_neg;
    logic [TERM_W:0]          r_term;
    logic [DIV_W-1:0]         r_vq;
    logic                     r_vup;

    logic [SAMPLE_W-1:0]      r_mean_out;
    logic [SUM_W-1:0]         r_var_out;
    logic [CNT_OUT_W-1:0]     r_cnt_out;
    logic                     r_sat_out;

    t_div_req w_div_req;
    t_div_rsp w_div_rsp;
    t_mul_req w_mul_req;
    t_mul_rsp w_mul_rsp;

    logic                  w_in_ready;
    logic                  w_accept;
    logic                  w_load;
    logic [MEAN_W-1:0]     w_x;
    logic [MEAN_W:0]       w_dp;
    logic [MEAN_W:0]       w_dn;
    logic [MEAN_W:0]       w_d2p;
    logic [MEAN_W:0]       w_d2n;
    logic [MAG_W-1:0]      w_d2m;
    logic [NUM_W-1:0]      w_num;
    logic [MAG_W-1:0]      w_q;
    logic [SUM_W:0]        w_sum;
    logic [MEAN_W:0]       w_mean_rnd;
    logic [CNT_EXT_W-1:0]  w_cnt_ext;
    logic                  w_cnt_over;

    assign w_x   = {r_sample, FRAC_SHIFT'(0)};
    assign w_dp  = {w_x[MEAN_W-1], w_x} - {r_mean[MEAN_W-1], r_mean};
    assign w_dn  = {r_mean[MEAN_W-1], r_mean} - {w_x[MEAN_W-1], w_x};
    assign w_d2p = w_dp;
    assign w_d2n = w_dn;
    assign w_d2m = w_d2p[MEAN_W] ? w_d2n[MAG_W-1:0] : w_d2p[MAG_W-1:0];
    assign w_num = NUM_W'(r_dm) + NUM_W'(r_count >> 1);
    assign w_q   = w_div_rsp.quot[MAG_W-1:0];
    assign w_sum = {1'b0, r_sum} + {1'b0, r_term[TERM_W-1:0]};

    assign w_mean_rnd = {r_mean[MEAN_W-1], r_mean} + (MEAN_W+1)'(1 << (FRAC_SHIFT - 1));
    assign w_cnt_ext  = CNT_EXT_W'(r_count);
    assign w_cnt_over = w_cnt_ext > CNT_EXT_W'(CNT_OUT_MAX);

    assign w_accept = i_in.valid && w_in_ready;
    assign w_load   = (r_state == S_EMIT) && (!r_out_valid || o_out.ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (w_accept) n_state = S_DIFF;
            S_DIFF:     n_state = S_DIV_GO;
            S_DIV_GO:   n_state = S_DIV_MEAN;
            S_DIV_MEAN: if (w_div_rsp.done) n_state = S_D2;
            S_D2:       n_state = S_MUL;
            S_MUL:      if (w_mul_rsp.done) n_state = S_ACC;
            S_ACC:      n_state = r_last ? S_VAR_GO : S_IDLE;
            S_VAR_GO:   n_state = S_DIV_VAR;
            S_DIV_VAR:  if (w_div_rsp.done) n_state = S_EMIT;
            S_EMIT:     if (w_load) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // controller outputs
    always_comb begin
        w_in_ready         = 1'b0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = {w_num, (DIV_W-NUM_W)'(0)};
        w_div_req.divisor  = r_count;
        w_div_req.steps    = DIV_CNT_W'(NUM_W);
        w_mul_req.start    = 1'b0;
        w_mul_req.a        = r_dm;
        w_mul_req.b        = w_d2m;
        unique case (r_state)
            S_IDLE:   w_in_ready = 1'b1;
            S_DIV_GO: w_div_req.start = 1'b1;
            S_D2:     w_mul_req.start = 1'b1;
            S_VAR_GO: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = r_sum;
                w_div_req.steps    = DIV_CNT_W'(DIV_W);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mean      <= '0;
            r_sum       <= '0;
            r_count     <= '0;
            r_flag      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (r_count == COUNT_MAX) begin
                            r_flag <= 1'b1;
                        end else begin
                            r_count <= r_count + COUNT_BITS'(1);
                        end
                    end
                end
                S_DIV_MEAN: begin
                    if (w_div_rsp.done) begin
                        r_mean <= r_neg ? r_mean - MEAN_W'(w_q) : r_mean + MEAN_W'(w_q);
                    end
                end
                S_ACC: begin
                    if (r_term[TERM_W] || w_sum[SUM_W]) begin
                        r_sum  <= '1;
                        r_flag <= 1'b1;
                    end else begin
                        r_sum <= w_sum[SUM_W-1:0];
                    end
                end
                S_EMIT: begin
                    if (w_load) begin
                        r_mean      <= '0;
                        r_sum       <= '0;
                        r_count     <= '0;
                        r_flag      <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= i_in.sample;
            r_last   <= i_in.last;
        end
        if (r_state == S_DIFF) begin
            r_neg <= w_dp[MEAN_W];
            r_dm  <= w_dp[MEAN_W] ? w_dn[MAG_W-1:0] : w_dp[MAG_W-1:0];
        end
        if ((r_state == S_MUL) && w_mul_rsp.done) begin
            r_term <= {1'b0, w_mul_rsp.prod[PROD_W-1:PROD_SHIFT]}
                      + (TERM_W+1)'(w_mul_rsp.prod[PROD_SHIFT-1]);
        end
        if ((r_state == S_DIV_VAR) && w_div_rsp.done) begin
            r_vq  <= w_div_rsp.quot;
            r_vup <= {w_div_rsp.rem, 1'b0} >= {1'b0, r_count};
        end
        if (w_load) begin
            r_mean_out <= w_mean_rnd[FRAC_SHIFT+SAMPLE_W-1:FRAC_SHIFT];
            r_var_out  <= r_vq + SUM_W'(r_vup);
            r_cnt_out  <= w_cnt_over ? CNT_OUT_MAX : CNT_OUT_W'(r_count);
            r_sat_out  <= r_flag || w_cnt_over;
        end
    end

    rmv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    rmv_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    assign i_in.ready         = w_in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.mean_out     = r_mean_out;
    assign o_out.variance_out = r_var_out;
    assign o_out.sample_count = r_cnt_out;
    assign o_out.saturated    = r_sat_out;

endmodule

`default_nettype wire
